// ===== rtl/piecewise_quintic_evaluator_core_assert.svh =====
// Assertion macros shared by the evaluator modules.
`ifndef PIECEWISE_QUINTIC_EVALUATOR_CORE_ASSERT_SVH
`define PIECEWISE_QUINTIC_EVALUATOR_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PQE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PQE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/pqe_pkg.sv =====
// Shared types and constants of the piecewise quintic evaluator.
`default_nettype none
package pqe_pkg;
  localparam int MaxSegments = 16;
  localparam int SegW = $clog2(MaxSegments);
  localparam int CoefDepth = 6 * MaxSegments;
  localparam int CoefAw = $clog2(CoefDepth);
  localparam logic [23:0] EndTol = 24'd66;
  localparam logic [1:0] KIND_COEF = 2'd0;
  localparam logic [1:0] KIND_DUR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic       sum_clr;     // clear running sums
    logic       sum_acc;     // add duration read data to total
    logic       srch_step;   // advance the walk past the current segment
    logic       dur_rd;      // issue duration read at dur_addr
    logic [SegW-1:0] dur_addr;
    logic       end_dec;     // decide end or search
    logic       coef_rd;     // issue coefficient read
    logic [2:0] coef_pow;
    logic       h_load;      // load accumulators with top coefficient
    logic       h_mul;       // multiply step
    logic       h_add;       // add step
    logic [2:0] h_pow;       // coefficient power for load, multiply and add steps
    logic       done;        // present result
  } pqe_cmd_t;

  typedef struct packed {
    logic       q_gt_end;    // query beyond current running end
    logic       is_end;
  } pqe_sts_t;
endpackage
`default_nettype wire

// ===== rtl/pqe_ctrl.sv =====
// Controller state machine sequencing summation, search and Horner steps.
`default_nettype none
`include "piecewise_quintic_evaluator_core_assert.svh"
module pqe_ctrl import pqe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [SegW:0] n_used,
  input  wire pqe_sts_t    sts,
  output logic             busy,
  output pqe_cmd_t         cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_SUMW, S_DEC, S_SRCH, S_SRCHW, S_CRD, S_CLD, S_MUL, S_ADD, S_DONE
  } state_t;

  state_t state_r;
  logic [SegW:0] cnt_r;
  logic [2:0] pow_r;
  logic step_ok;

  // The walk moves on only while the query lies past the running end and a
  // further segment is in use.
  assign step_ok = sts.q_gt_end && (cnt_r + 1'b1 < n_used);

  always_comb begin
    cmd = '0;
    cmd.dur_addr = cnt_r[SegW-1:0];
    cmd.coef_pow = pow_r;
    cmd.h_pow = pow_r;
    case (state_r)
      S_IDLE: cmd.sum_clr = go;
      S_SUM: cmd.dur_rd = 1'b1;
      S_SUMW: cmd.sum_acc = 1'b1;
      S_DEC: cmd.end_dec = 1'b1;
      S_SRCH: cmd.dur_rd = 1'b1;
      S_SRCHW: cmd.srch_step = step_ok;
      S_CRD: cmd.coef_rd = 1'b1;
      S_CLD: cmd.h_load = 1'b1;
      S_MUL: cmd.h_mul = 1'b1;
      S_ADD: cmd.h_add = 1'b1;
      S_DONE: cmd.done = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      pow_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (go) begin
          state_r <= S_SUM;
          cnt_r <= '0;
        end
        S_SUM: state_r <= S_SUMW;
        S_SUMW: begin
          if (cnt_r + 1'b1 == n_used) begin
            state_r <= S_DEC;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            state_r <= S_SUM;
          end
        end
        S_DEC: begin
          // Past the end the counter already points at the last segment in use.
          if (sts.is_end) begin
            pow_r <= 3'd5;
            state_r <= S_CRD;
          end else begin
            cnt_r <= '0;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: state_r <= S_SRCHW;
        S_SRCHW: begin
          if (step_ok) begin
            cnt_r <= cnt_r + 1'b1;
            state_r <= S_SRCH;
          end else begin
            pow_r <= 3'd5;
            state_r <= S_CRD;
          end
        end
        S_CRD: state_r <= (pow_r == 3'd5) ? S_CLD : S_ADD;
        S_CLD: begin
          pow_r <= 3'd4;
          state_r <= S_MUL;
        end
        S_MUL: state_r <= S_CRD;
        S_ADD: begin
          if (pow_r == 3'd0) begin
            state_r <= S_DONE;
          end else begin
            pow_r <= pow_r - 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PQE_ASSERT_IMP(a_go_idle, clk, rst_n, go, state_r == S_IDLE, "start taken while busy")
  `PQE_ASSERT_NXT(a_done_idle, clk, rst_n, state_r == S_DONE, state_r == S_IDLE,
    "done not followed by idle")
  `PQE_ASSERT_IMP(a_cnt_rng, clk, rst_n, busy, cnt_r < n_used, "segment counter out of range")
endmodule
`default_nettype wire

// ===== rtl/pqe_datapath.sv =====
// Datapath: coefficient and duration memories, segment search and three Horner lanes.
`default_nettype none
`include "piecewise_quintic_evaluator_core_assert.svh"
module pqe_datapath import pqe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_coef,
  input  wire logic               wr_dur,
  input  wire logic [SegW-1:0]    wr_seg,
  input  wire logic [2:0]         wr_pow,
  input  wire logic signed [31:0] wr_val,
  input  wire logic               q_load,
  input  wire logic [23:0]        q_time,
  input  wire pqe_cmd_t           cmd,
  output pqe_sts_t                sts,
  output logic signed [31:0]      pos,
  output logic signed [31:0]      vel,
  output logic signed [31:0]      acc,
  output logic [SegW-1:0]         seg_out,
  output logic                    at_end,
  output logic                    sat
);
  localparam logic signed [39:0] AccMax = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] AccMin = {1'b1, {39{1'b0}}};

  logic signed [31:0] coef_mem [CoefDepth];
  logic [23:0] dur_mem [MaxSegments];
  logic signed [31:0] coef_rd_r;
  logic [23:0] dur_rd_r;
  logic [23:0] q_r;
  logic [28:0] total_r, t_bot_r;
  logic is_end_r;
  logic [23:0] tl_r;
  logic signed [39:0] hp_r, hv_r, ha_r;
  logic sat_r;
  logic [28:0] run_end;
  logic end_now;

  always_ff @(posedge clk) begin
    if (wr_coef) coef_mem[CoefAw'({wr_seg, 3'b000} - {1'b0, wr_seg, 1'b0}) + CoefAw'(wr_pow)]
      <= wr_val;
    if (wr_dur) dur_mem[wr_seg] <= wr_val[23:0];
    if (cmd.coef_rd)
      coef_rd_r <= coef_mem[CoefAw'({cmd.dur_addr, 3'b000} - {1'b0, cmd.dur_addr, 1'b0})
                            + CoefAw'(cmd.coef_pow)];
    if (cmd.dur_rd) dur_rd_r <= dur_mem[cmd.dur_addr];
  end

  function automatic logic signed [39:0] clip40(input logic signed [47:0] v,
                                                 output logic f);
    f = 1'b0;
    if (v > 48'(AccMax)) begin f = 1'b1; return AccMax; end
    if (v < 48'(AccMin)) begin f = 1'b1; return AccMin; end
    return v[39:0];
  endfunction

  function automatic logic signed [39:0] hmul(input logic signed [39:0] a,
                                              input logic [23:0] t, output logic f);
    logic signed [64:0] p;
    p = a * $signed({1'b0, t});
    p = p + 65'sd32768;
    p = p >>> 16;
    f = 1'b0;
    if (p > 65'(AccMax)) begin f = 1'b1; return AccMax; end
    if (p < 65'(AccMin)) begin f = 1'b1; return AccMin; end
    return p[39:0];
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [39:0] v,
                                                output logic f);
    f = 1'b0;
    if (v > 40'sh007FFFFFFF) begin f = 1'b1; return 32'sh7FFFFFFF; end
    if (v < -40'sh0080000000) begin f = 1'b1; return 32'sh80000000; end
    return v[31:0];
  endfunction

  logic signed [37:0] c38, kv, ka;
  logic lane_v, lane_a;
  logic fp, fv, fa, fo1, fo2, fo3;
  logic signed [39:0] np, nv, na;
  logic signed [31:0] op, ov, oa;

  // Coefficient c[p] feeds all three lanes: position adds c[p], velocity adds
  // p*c[p] one step behind, acceleration adds p*(p-1)*c[p] two steps behind.
  always_comb begin
    c38 = 38'(coef_rd_r);
    case (cmd.h_pow)
      3'd5: begin kv = (c38 <<< 2) + c38; ka = (c38 <<< 4) + (c38 <<< 2); end
      3'd4: begin kv = c38 <<< 2; ka = (c38 <<< 3) + (c38 <<< 2); end
      3'd3: begin kv = (c38 <<< 1) + c38; ka = (c38 <<< 2) + (c38 <<< 1); end
      3'd2: begin kv = c38 <<< 1; ka = c38 <<< 1; end
      3'd1: begin kv = c38; ka = '0; end
      default: begin kv = '0; ka = '0; end
    endcase
    lane_v = (cmd.h_pow != 3'd0);
    lane_a = (cmd.h_pow > 3'd1);
    np = hp_r; nv = hv_r; na = ha_r; fp = 1'b0; fv = 1'b0; fa = 1'b0;
    if (cmd.h_load) begin
      np = 40'(coef_rd_r);
      nv = 40'(kv);
      na = 40'(ka);
    end else if (cmd.h_mul) begin
      np = hmul(hp_r, tl_r, fp);
      if (lane_v) nv = hmul(hv_r, tl_r, fv);
      if (lane_a) na = hmul(ha_r, tl_r, fa);
    end else if (cmd.h_add) begin
      np = clip40(48'(hp_r) + 48'(coef_rd_r), fp);
      if (lane_v) nv = clip40(48'(hv_r) + 48'(kv), fv);
      if (lane_a) na = clip40(48'(ha_r) + 48'(ka), fa);
    end
    op = clip32(hp_r, fo1);
    ov = clip32(hv_r, fo2);
    oa = clip32(ha_r, fo3);
  end

  assign run_end = t_bot_r + 29'(dur_rd_r);
  assign end_now = (29'(q_r) + 29'(EndTol)) >= total_r;
  assign sts = '{q_gt_end: (29'(q_r) > run_end), is_end: end_now};

  always_ff @(posedge clk) begin
    if (q_load) q_r <= q_time;
    if (cmd.sum_clr) total_r <= '0;
    else if (cmd.sum_acc) total_r <= total_r + 29'(dur_rd_r);
    if (cmd.end_dec) begin
      is_end_r <= end_now;
      t_bot_r <= '0;
    end else if (cmd.srch_step) begin
      t_bot_r <= run_end;
    end
    // Past the end the last duration read during summation is still held.
    if (cmd.coef_rd && cmd.coef_pow == 3'd5) begin
      tl_r <= is_end_r ? dur_rd_r : 24'(29'(q_r) - t_bot_r);
    end
    hp_r <= np; hv_r <= nv; ha_r <= na;
    if (cmd.h_load) sat_r <= 1'b0;
    else sat_r <= sat_r | fp | (!is_end_r & (fv | fa));
    if (cmd.done) begin
      pos <= op;
      vel <= is_end_r ? 32'sd0 : ov;
      acc <= is_end_r ? 32'sd0 : oa;
      seg_out <= cmd.dur_addr;
      at_end <= is_end_r;
      sat <= sat_r | fo1 | (!is_end_r & (fo2 | fo3));
    end
  end

  `PQE_ASSERT_IMP(a_rd_excl, clk, rst_n, cmd.coef_rd, !cmd.dur_rd, "two reads in one step")
  `PQE_ASSERT_IMP(a_step_excl, clk, rst_n, cmd.h_mul, !cmd.h_add && !cmd.h_load,
    "Horner step conflict")
  `PQE_ASSERT_NXT(a_tl_rng, clk, rst_n, cmd.h_load && !is_end_r, 29'(tl_r) <= 29'(q_r),
    "local time beyond query")
endmodule
`default_nettype wire

// ===== rtl/piecewise_quintic_evaluator_core.sv =====
// Top level of the piecewise quintic trajectory evaluator.
// Usage: items enter on in_* when start is high and busy is low. Kind 0 loads a
// Q16.16 coefficient, kind 1 a Q8.16 duration; both keep busy low and give no
// result, so loads can follow back to back.
// Kind 2 is a query: busy rises, the controller sums the durations of the N
// segments in use, decides whether the query lies past the end, walks the
// cumulative ends (no walk past the end), then runs the Horner steps of the
// position, velocity and acceleration lanes in parallel, one coefficient read
// per power, and presents the result. The single read port of each store sets
// how long busy stays high. The result appears on out_* marked by out_valid,
// high for a single cycle, in the same cycle that busy falls; the receiver
// cannot stall it.
// cfg_we writes segment_count; the user must write it only in an idle cycle,
// and the block itself does not enforce this.
// Reset clears the controller and sets segment_count to one; the stores stay
// undefined until loaded.
`default_nettype none
module piecewise_quintic_evaluator_core import pqe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_kind,
  input  wire logic [3:0]         in_segment_index,
  input  wire logic [2:0]         in_coefficient_index,
  input  wire logic signed [31:0] in_load_value,
  input  wire logic [23:0]        in_query_time,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_wdata,
  output logic                    out_valid,
  output logic signed [31:0]      out_position,
  output logic signed [31:0]      out_velocity,
  output logic signed [31:0]      out_acceleration,
  output logic [3:0]              out_segment_used,
  output logic                    out_at_end,
  output logic                    out_saturated
);
  logic [4:0] seg_cnt_r;
  logic [SegW:0] n_used;
  logic acc_t, go;
  pqe_cmd_t cmd;
  pqe_sts_t sts;
  logic valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) seg_cnt_r <= 5'd1;
    else if (cfg_we) seg_cnt_r <= cfg_wdata;
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= cmd.done;
  end
  always_comb begin
    if (seg_cnt_r == 5'd0) n_used = (SegW+1)'(1);
    else if (seg_cnt_r > 5'(MaxSegments)) n_used = (SegW+1)'(MaxSegments);
    else n_used = (SegW+1)'(seg_cnt_r);
  end
  assign acc_t = start && !busy;
  assign go = acc_t && (in_kind == KIND_QUERY);

  pqe_ctrl u_ctrl (.clk, .rst_n, .go, .n_used, .sts, .busy, .cmd);

  pqe_datapath u_dp (
    .clk, .rst_n,
    .wr_coef(acc_t && in_kind == KIND_COEF && in_coefficient_index <= 3'd5),
    .wr_dur(acc_t && in_kind == KIND_DUR),
    .wr_seg(in_segment_index), .wr_pow(in_coefficient_index), .wr_val(in_load_value),
    .q_load(go), .q_time(in_query_time), .cmd, .sts,
    .pos(out_position), .vel(out_velocity), .acc(out_acceleration),
    .seg_out(out_segment_used), .at_end(out_at_end), .sat(out_saturated));
  assign out_valid = valid_r;
endmodule
`default_nettype wire
